### design/rhsi_pkg.sv
// Shared types, constants and tables for the RGB to HSI pixel converter.
// No dependencies.
package rhsi_pkg;

  localparam int CORDIC_STEPS = 16;   // 8..24, also covers the 8 divide steps
  localparam int DIV_STEPS    = 8;
  localparam int XW           = 30;   // CORDIC x/y width, holds gain growth
  localparam int IDX_W        = 5;
  localparam logic [17:0] SQRT3_Q16 = 18'd113512;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [31:0]          ang;
    logic [18:0]          rem;      // divide remainder
    logic [10:0]          den;      // 2*sum
    logic [7:0]           quo;
    logic [7:0]           inten;
    logic                 sat_ok;
    logic                 grey;
    logic                 spec;     // hue is an exact multiple of 60 deg
    logic [7:0]           spec_hue;
  } pix_t;

  // atan(2^-i) in 2^-32 turns
  function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### design/rhsi_front.sv
// Input stage: sum, min, intensity, divide operands, CORDIC seed, special hues.
// Depends on rhsi_pkg.
module rhsi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vin,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic                method,
  output logic                vout_r,
  output rhsi_pkg::pix_t      dout_r
);
  import rhsi_pkg::*;

  logic [9:0]           sum;
  logic [7:0]           mn;
  logic [9:0]           diff;
  logic [9:0]           ivec;
  logic [21:0]          iprod;
  logic [7:0]           inten;
  logic signed [10:0]   xd;
  logic signed [8:0]    yd;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic [18:0]          num;
  pix_t                 p;

  always_comb begin
    sum  = {2'b0, red} + {2'b0, green} + {2'b0, blue};
    mn   = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    diff = sum - 10'(3 * {2'b0, mn});
    // 510*diff + sum
    num  = 19'({diff, 9'b0}) - 19'({diff, 1'b0}) + 19'(sum);
    ivec  = method ? sum + 10'd1 : sum;
    iprod = 22'(ivec) * 22'd2731;     // /3 by reciprocal, exact below 8192
    inten = iprod[20:13];
    xd = $signed({3'b0, red} <<< 1) - $signed({3'b0, green}) - $signed({3'b0, blue});
    yd = $signed({1'b0, green}) - $signed({1'b0, blue});
    x0 = $signed({{(XW-27){xd[10]}}, xd, 16'b0});
    y0 = XW'($signed({{(XW-9){yd[8]}}, yd}) * $signed({{(XW-18){1'b0}}, SQRT3_Q16}));

    p        = '0;
    p.rem    = num;
    p.den    = {sum, 1'b0};
    p.inten  = inten;
    p.sat_ok = method ? (sum != 10'd0) : (inten != 8'd0);
    p.grey   = (red == green) && (green == blue);
    if (xd < 0) begin
      p.x   = -x0;
      p.y   = -y0;
      p.ang = HALF_TURN;
    end else begin
      p.x   = x0;
      p.y   = y0;
      p.ang = '0;
    end
    p.spec = 1'b1;
    if (green == blue)      p.spec_hue = (red > green) ? 8'd0 : 8'd128;
    else if (red == green)  p.spec_hue = (red > blue) ? 8'd43 : 8'd170;
    else if (red == blue)   p.spec_hue = (red > green) ? 8'd213 : 8'd85;
    else begin
      p.spec     = 1'b0;
      p.spec_hue = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (en) begin
      vout_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= p;
    end
  end

endmodule

### design/rhsi_stage.sv
// One pipeline stage: a CORDIC vectoring step and, in the first stages,
// one quotient bit of the saturation divide. Depends on rhsi_pkg.
module rhsi_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [rhsi_pkg::IDX_W-1:0]    idx,
  input  logic                          vin,
  input  rhsi_pkg::pix_t                din,
  output logic                          vout_r,
  output rhsi_pkg::pix_t                dout_r
);
  import rhsi_pkg::*;

  pix_t                 p;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic [2:0]           qsh;
  logic [18:0]          dsh;

  always_comb begin
    p  = din;
    dx = din.y >>> idx;
    dy = din.x >>> idx;
    if (!din.y[XW-1]) begin
      p.x   = din.x + dx;
      p.y   = din.y - dy;
      p.ang = din.ang + atan_turn(idx);
    end else begin
      p.x   = din.x - dx;
      p.y   = din.y + dy;
      p.ang = din.ang - atan_turn(idx);
    end
    // restoring divide, MSB quotient bit first
    qsh = 3'(DIV_STEPS - 1) - idx[2:0];
    dsh = 19'(din.den) << qsh;
    if (idx < IDX_W'(DIV_STEPS)) begin
      if (din.rem >= dsh) begin
        p.rem      = din.rem - dsh;
        p.quo[qsh] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (en) begin
      vout_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= p;
    end
  end

endmodule

### design/rgb_to_hsi_pixel.sv
// Top level: RGB to HSI pixel converter, pipelined CORDIC hue and divider.
// Depends on rhsi_pkg, rhsi_front, rhsi_stage.
//
//   channel  dir  word fields (low bit up)
//   in_*     in   tdata: red[7:0] green[15:8] blue[23:16]
//   out_*    out  tdata: hue[7:0] sat[15:8] inten[23:16]; tuser: hue_valid
//   cfg_*    in   cfg_wdata: method_select
//
// The pipeline holds a front stage, one stage per CORDIC step (the first eight
// also hold one divide bit each) and an output register. One word per cycle
// sustained while out_tready stays high. Each stage advances when it is empty or
// the next one moves, so bubbles close up under back-pressure and nothing is lost.
// Synchronous active-low reset clears the valid bits and method_select.
module rgb_to_hsi_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // red, green, blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // hue_out, saturation_out, intensity_out
  output logic        out_tuser,    // hue_valid
  input  logic        cfg_wen,
  input  logic        cfg_wdata
);
  import rhsi_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic        method_r;
  logic        v_r   [0:N];
  pix_t        d_r   [0:N];
  logic        en    [0:N];
  logic        en_out;
  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic        out_user_r;
  logic [39:0] hprod;
  logic [7:0]  hue;
  logic [23:0] out_data_nxt;
  logic        out_user_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= 1'b0;
    end else if (cfg_wen) begin
      method_r <= cfg_wdata;
    end
  end

  assign en_out = !out_valid_r || out_tready;

  always_comb begin
    en[N] = !v_r[N] || en_out;
    for (int i = N - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_tready = en[0];

  rhsi_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en[0]),
    .vin    (in_tvalid),
    .red    (in_tdata[7:0]),
    .green  (in_tdata[15:8]),
    .blue   (in_tdata[23:16]),
    .method (method_r),
    .vout_r (v_r[0]),
    .dout_r (d_r[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_stage
    rhsi_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en[g+1]),
      .idx    (IDX_W'(g)),
      .vin    (v_r[g]),
      .din    (d_r[g]),
      .vout_r (v_r[g+1]),
      .dout_r (d_r[g+1])
    );
  end

  always_comb begin
    // ang*255 + half, keep the top byte
    hprod = {d_r[N].ang, 8'b0} - {8'b0, d_r[N].ang} + 40'h00_8000_0000;
    if (d_r[N].grey)      hue = 8'd0;
    else if (d_r[N].spec) hue = d_r[N].spec_hue;
    else                  hue = hprod[39:32];
    out_data_nxt = {d_r[N].inten, (d_r[N].sat_ok ? d_r[N].quo : 8'd0), hue};
    out_user_nxt = !d_r[N].grey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_user_r |-> out_data_r[7:0] == 8'd0)
    else $error("grey word with nonzero hue");

  a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted word missing from front stage");

  a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !method_r && out_data_r[23:16] == 8'd0 |-> out_data_r[15:8] == 8'd0)
    else $error("saturation set with zero intensity");

  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[N] && !en[N] |=> v_r[N] && $stable(d_r[N].ang))
    else $error("last stage lost a stalled word");
`endif

endmodule
